>>> design/sbsr_pkg.sv
// sbsr_pkg: shared constants, types and the quarter-wave sine table
// for the sine burst with sine-squared rise block.
// No dependencies; every other design file imports it.
package sbsr_pkg;

  // table and time sizing
  localparam int SINE_TABLE_BITS = 10;
  localparam int TIME_BITS       = 32;
  localparam int QSIZE           = 1 << SINE_TABLE_BITS;
  localparam int IDX_W           = SINE_TABLE_BITS + 1;
  localparam int SINE_W          = 16;
  localparam int CSHIFT          = 30 - SINE_TABLE_BITS;
  localparam int ESHIFT          = 32 - SINE_TABLE_BITS;

  localparam logic [31:0] TIME_MASK = (TIME_BITS >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << TIME_BITS) - 64'd1);

  // configuration port
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_START_TIME     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RISE_TIME      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RISE_RATE      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FREQUENCY_STEP = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_OFFSET   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE      = 3'd5;

  // region codes
  localparam logic [1:0] REGION_BEFORE = 2'd0;
  localparam logic [1:0] REGION_RISE   = 2'd1;
  localparam logic [1:0] REGION_FULL   = 2'd2;

  // envelope of one in Q2.30
  localparam logic [30:0] ENV_ONE = 31'h4000_0000;

  typedef struct packed {
    logic [31:0]        start_time;
    logic [31:0]        rise_time;
    logic [31:0]        rise_rate;
    logic [31:0]        frequency_step;
    logic [31:0]        phase_offset;
    logic signed [15:0] amplitude;
  } cfg_t;

  typedef logic [SINE_W-1:0] sine_tab_t [QSIZE+1];

  localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;

  // sin(x) for x in [0, pi/2], Q2.30 in and out, eight-term series
  function automatic logic [63:0] taylor_sin(input logic [63:0] x);
    logic [63:0] term;
    logic [63:0] sum;
    int          n;
    term = x;
    sum  = x;
    for (n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      unique case (n)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        6: term = term / 64'd156;
        7: term = term / 64'd210;
        default: term = term;
      endcase
      if (n % 2 == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // quarter-wave table in Q1.15, worked out at elaboration
  function automatic sine_tab_t build_table();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] v;
    int          k;
    for (k = 0; k <= QSIZE; k++) begin
      x = (HALFPI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
      v = (taylor_sin(x) + 64'd16384) >> 15;
      if (v > 64'd32768) begin
        v = 64'd32768;
      end
      tab[k] = v[SINE_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_table();

endpackage

>>> design/sbsr_regs.sv
// sbsr_regs: APB-style configuration registers of the sine burst block.
// Depends on sbsr_pkg for register codes and the cfg_t struct.
module sbsr_regs import sbsr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t                 cfg_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_o   = cfg_q;

  // register write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START_TIME:     cfg_q.start_time     <= pwdata;
        REG_RISE_TIME:      cfg_q.rise_time      <= pwdata;
        REG_RISE_RATE:      cfg_q.rise_rate      <= pwdata;
        REG_FREQUENCY_STEP: cfg_q.frequency_step <= pwdata;
        REG_PHASE_OFFSET:   cfg_q.phase_offset   <= pwdata;
        REG_AMPLITUDE:      cfg_q.amplitude      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_START_TIME:     prdata = cfg_q.start_time;
      REG_RISE_TIME:      prdata = cfg_q.rise_time;
      REG_RISE_RATE:      prdata = cfg_q.rise_rate;
      REG_FREQUENCY_STEP: prdata = cfg_q.frequency_step;
      REG_PHASE_OFFSET:   prdata = cfg_q.phase_offset;
      REG_AMPLITUDE:      prdata = {{16{cfg_q.amplitude[15]}}, cfg_q.amplitude};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

>>> design/sbsr_sine_rom.sv
// sbsr_sine_rom: two-port quarter-wave sine ROM with registered read data.
// Depends on sbsr_pkg for the table contents and index width.
module sbsr_sine_rom import sbsr_pkg::*; (
  input  logic              clk_i,
  input  logic              en_a_i,
  input  logic [IDX_W-1:0]  addr_a_i,
  output logic [SINE_W-1:0] data_a_o,
  input  logic              en_b_i,
  input  logic [IDX_W-1:0]  addr_b_i,
  output logic [SINE_W-1:0] data_b_o
);

  logic [SINE_W-1:0] data_a_q;
  logic [SINE_W-1:0] data_b_q;

  // registered reads, held while the stage is stalled
  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      data_a_q <= SINE_TAB[addr_a_i];
    end
    if (en_b_i) begin
      data_b_q <= SINE_TAB[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

>>> design/sine_burst_with_sine_squared_rise_core.sv
// sine_burst_with_sine_squared_rise_core: top level, seven-stage sample pipeline.
// Depends on sbsr_pkg, sbsr_regs and sbsr_sine_rom.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    time_ticks_i
//   out      output     out_valid_o / out_ready_i  sample_o, region_o
//   cfg      input      psel, penable, pwrite      paddr, pwdata, prdata
//
// One transfer per cycle sustained while the output is not stalled. Stages in
// order: time capture, carrier phase product, envelope phase product,
// registered table read, envelope square, final product, then rounding.
// Reset clears the valid bits and the config registers; the sine table is
// constant, no fill pass.
// Each stage advances when the one after it is empty or moving, so bubbles
// collapse and a stalled output holds without losing or repeating items.
module sine_burst_with_sine_squared_rise_core import sbsr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       time_ticks_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [15:0] sample_o,
  output logic [1:0]        region_o
);

  cfg_t cfg;

  sbsr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // valid bits and stage enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, out_valid_q;
  logic en1, en2, en3, en4, en5, en6, out_en;

  assign out_en     = !out_valid_q || out_ready_i;
  assign en6        = !v6_q || out_en;
  assign en5        = !v5_q || en6;
  assign en4        = !v4_q || en5;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    v1_q        <= in_valid_i;
      if (en2)    v2_q        <= v1_q;
      if (en3)    v3_q        <= v2_q;
      if (en4)    v4_q        <= v3_q;
      if (en5)    v5_q        <= v4_q;
      if (en6)    v6_q        <= v5_q;
      if (out_en) out_valid_q <= v6_q;
    end
  end

  // stage 1: capture the time
  logic [31:0] t1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      t1_q <= time_ticks_i & TIME_MASK;
    end
  end

  // stage 2: region decision, time since start, carrier phase product
  logic [32:0] end_sum;
  logic        before_start;
  logic        at_full;
  logic [1:0]  region2_d;
  logic [31:0] ph_mul;
  logic [31:0] dt2_q;
  logic [31:0] ph_mul2_q;
  logic [1:0]  region2_q;

  assign end_sum      = {1'b0, cfg.start_time} + {1'b0, cfg.rise_time};
  assign before_start = t1_q <= cfg.start_time;
  assign at_full      = {1'b0, t1_q} >= end_sum;
  assign ph_mul       = cfg.frequency_step * t1_q;

  always_comb begin
    priority if (before_start) begin
      region2_d = REGION_BEFORE;
    end else if (at_full) begin
      region2_d = REGION_FULL;
    end else begin
      region2_d = REGION_RISE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      dt2_q     <= t1_q - cfg.start_time;
      ph_mul2_q <= ph_mul;
      region2_q <= region2_d;
    end
  end

  // stage 3: envelope phase product, carrier phase sum
  logic [63:0] e_full;
  logic [63:0] e3_q;
  logic [31:0] phase3_q;
  logic [1:0]  region3_q;

  assign e_full = dt2_q * cfg.rise_rate;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      e3_q      <= e_full;
      phase3_q  <= ph_mul2_q + cfg.phase_offset;
      region3_q <= region2_q;
    end
  end

  // stage 4: table indexes and registered table reads
  logic [30:0]       c_sum;
  logic [IDX_W-1:0]  c_idx_raw;
  logic [IDX_W-1:0]  c_idx;
  logic [32:0]       e_sat;
  logic [33:0]       e_sum;
  logic [IDX_W-1:0]  e_idx;
  logic [SINE_W-1:0] sc4;
  logic [SINE_W-1:0] se4;
  logic              cneg4_q;
  logic [1:0]        region4_q;

  assign c_sum     = {1'b0, phase3_q[29:0]} + 31'(1 << (CSHIFT - 1));
  assign c_idx_raw = IDX_W'(c_sum >> CSHIFT);
  assign c_idx     = phase3_q[30] ? IDX_W'(QSIZE) - c_idx_raw : c_idx_raw;

  assign e_sat = (e3_q > 64'h1_0000_0000) ? 33'h1_0000_0000 : e3_q[32:0];
  assign e_sum = {1'b0, e_sat} + 34'(1 << (ESHIFT - 1));
  assign e_idx = IDX_W'(e_sum >> ESHIFT);

  sbsr_sine_rom u_rom (
    .clk_i    (clk_i),
    .en_a_i   (en4),
    .addr_a_i (c_idx),
    .data_a_o (sc4),
    .en_b_i   (en4),
    .addr_b_i (e_idx),
    .data_b_o (se4)
  );

  always_ff @(posedge clk_i) begin
    if (en4) begin
      cneg4_q   <= phase3_q[31];
      region4_q <= region3_q;
    end
  end

  // stage 5: envelope square and amplitude times sine magnitude
  logic [15:0] amp_mag;
  logic [31:0] env_sq;
  logic [31:0] pmag_full;
  logic [30:0] env5_q;
  logic [30:0] pmag5_q;
  logic        neg5_q;
  logic [1:0]  region5_q;

  assign amp_mag   = cfg.amplitude[15] ? 16'(-cfg.amplitude) : cfg.amplitude;
  assign env_sq    = se4 * se4;
  assign pmag_full = amp_mag * sc4;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      env5_q    <= (region4_q == REGION_FULL) ? ENV_ONE : env_sq[30:0];
      pmag5_q   <= pmag_full[30:0];
      neg5_q    <= cfg.amplitude[15] ^ cneg4_q;
      region5_q <= region4_q;
    end
  end

  // stage 6: final product
  logic [61:0] mag_full;
  logic [61:0] mag6_q;
  logic        neg6_q;
  logic [1:0]  region6_q;

  assign mag_full = pmag5_q * env5_q;

  always_ff @(posedge clk_i) begin
    if (en6) begin
      mag6_q    <= mag_full;
      neg6_q    <= neg5_q;
      region6_q <= region5_q;
    end
  end

  // output stage: zero before start, else round half away from zero, saturate
  logic [62:0]        r_sum;
  logic [17:0]        r_mag;
  logic signed [15:0] sample_d;
  logic signed [15:0] sample_q;
  logic [1:0]         region_q;

  assign r_sum = {1'b0, mag6_q} + 63'(64'd1 << 44);
  assign r_mag = 18'(r_sum >> 45);

  always_comb begin
    priority if (region6_q == REGION_BEFORE) begin
      sample_d = 16'sd0;
    end else if (neg6_q) begin
      sample_d = (r_mag > 18'd32768) ? 16'sh8000 : 16'(18'd0 - r_mag);
    end else begin
      sample_d = (r_mag > 18'd32767) ? 16'sh7FFF : 16'(r_mag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      sample_q <= sample_d;
      region_q <= region6_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign region_o    = region_q;

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted transfer did not enter stage 1");

  a_ready_low_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v1_q && v2_q && v3_q && v4_q && v5_q && v6_q && out_valid_q)
    else $error("input stalled while the pipeline has a bubble");

  a_drain_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q && out_en |=> out_valid_q)
    else $error("stage 6 item lost on its way to the output");

  a_before_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && region_q == REGION_BEFORE |-> sample_q == 16'sd0)
    else $error("nonzero sample before start time");

  a_env_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> env5_q <= ENV_ONE)
    else $error("envelope above one");
`endif

endmodule
